@@ sv/tlik_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared types, widths, constants and helper functions for the two-link
// inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package tlik_pkg;

  localparam int CoordW    = 16;  // coordinate and output width
  localparam int LenW      = 15;  // link length width
  localparam int AngW      = 16;  // binary angle width
  localparam int NW        = 36;  // numerator / denominator width
  localparam int CW        = 45;  // vectoring x/y width after normalization
  localparam int ZW        = 34;  // cordic angle accumulator width
  localparam int RW        = 34;  // rotation x/y width (Q30)
  localparam int PW        = 50;  // length times cos/sin product width
  localparam int SatW      = 21;  // width fed to the coordinate clamp
  localparam int SqrtSteps = 32;  // one result bit per stage
  localparam int NormBit   = 40;  // operands are doubled up to 2^40
  localparam int KW        = 6;   // normalization shift count width
  localparam int MaxStages = 32;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic [LenW-1:0] LEN_RESET = 15'd6554;
  localparam logic [0:0] REG_UPPER = 1'b0;
  localparam logic [0:0] REG_LOWER = 1'b1;
  localparam logic signed [RW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [AngW-1:0] ANG_PI = 16'h8000;

  typedef enum logic [1:0] {
    ST_SOLVED       = 2'd0,
    ST_OUT_OF_REACH = 2'd1,
    ST_SINGULAR     = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
  } target_t;

  typedef struct packed {
    logic signed [AngW-1:0]   shoulder_angle;
    logic signed [AngW-1:0]   second_link_angle;
    logic signed [CoordW-1:0] elbow_x;
    logic signed [CoordW-1:0] elbow_y;
    logic signed [CoordW-1:0] tip_x;
    logic signed [CoordW-1:0] tip_y;
    status_t                  status;
  } solution_t;

  // terms that travel alongside the square root
  typedef struct packed {
    logic                 oor;
    logic [LenW-1:0]      len_a;
    logic [LenW-1:0]      len_b;
    logic signed [NW-1:0] ay2;
    logic signed [NW-1:0] by2;
    logic signed [NW-1:0] den0;
    logic signed [NW-1:0] den1;
  } front_t;

  // flags that travel with the vectoring lanes
  typedef struct packed {
    logic            oor;
    logic            sing;
    logic            pi0;
    logic            pi1;
    logic [LenW-1:0] len_a;
    logic [LenW-1:0] len_b;
  } vec_side_t;

  // solved angles handed to forward kinematics
  typedef struct packed {
    logic [AngW-1:0] ang0;
    logic [AngW-1:0] ang1;
    status_t         status;
    logic [LenW-1:0] len_a;
    logic [LenW-1:0] len_b;
  } angles_t;

  // atan(2^-i) in units of pi/2^31
  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [ZW-1:0] v;
    unique case (i)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      24: v = 34'sd41;
      25: v = 34'sd20;
      26: v = 34'sd10;
      27: v = 34'sd5;
      28: v = 34'sd3;
      29: v = 34'sd1;
      30: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // doublings needed until the magnitude reaches 2^NormBit
  function automatic logic [KW-1:0] norm_shift(input logic [NW-1:0] m);
    logic [KW-1:0] k;
    k = '0;
    for (int j = 0; j < NW; j++) begin
      if (m[j]) begin
        k = (j >= NormBit) ? '0 : KW'(NormBit - j);
      end
    end
    return k;
  endfunction

  // clamp to the signed coordinate range
  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [SatW-1:0] v);
    logic signed [CoordW-1:0] r;
    if (v > SatW'(2 ** (CoordW - 1) - 1)) begin
      r = {1'b0, {(CoordW - 1){1'b1}}};
    end else if (v < -SatW'(2 ** (CoordW - 1))) begin
      r = {1'b1, {(CoordW - 1){1'b0}}};
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/two_link_inverse_kinematics.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics
// Planar two-link arm solver: target point in, joint angles and the elbow
// and tip positions out, fully pipelined.
// ----------------------------------------------------------------------------
// usage
//   target channel: target_valid / target_stall / target (x, y in Q3.13).
//   solution channel: solution_valid / solution_stall / solution, holding
//     shoulder and second link angles (pi/32768 units), elbow and tip in
//     Q3.13 and a status code (solved, out of reach, singular).
//   cfg port: cfg_write with cfg_index and cfg_data sets the upper (index 0)
//     and lower (index 1) link lengths; write only while no word is in
//     flight.
//   throughput: one word per cycle while target_stall stays low.
//   path: each accepted word passes the front products, the 32-step square
//     root and the two cordic chains (vectoring, then rotation) before the
//     result word.
//   reset: rst clears every valid bit and loads both lengths with 6554.
//   stall: the pipeline keeps moving while the output word waits; one more
//     word is caught in a skid register, and only then target_stall rises.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics #(
  parameter int CORDIC_STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        target_valid,
  output logic                        target_stall,
  input  tlik_pkg::target_t           target,
  output logic                        solution_valid,
  input  logic                        solution_stall,
  output tlik_pkg::solution_t         solution,
  input  logic                        cfg_write,
  input  logic [0:0]                  cfg_index,
  input  logic [tlik_pkg::LenW-1:0]   cfg_data
);
  import tlik_pkg::*;

  // link length registers
  logic [LenW-1:0] upper_len, lower_len;

  // pipeline advance enable, low only while the skid word is held
  logic ce;

  logic              fr_valid;
  logic [63:0]       fr_radicand;
  front_t            fr_side;
  logic              sq_valid;
  logic [31:0]       sq_root;
  front_t            sq_side;
  logic              vc_valid;
  angles_t           vc_angles;
  logic              rt_valid;
  solution_t         rt_sol;

  // skid word
  logic              skid_valid;
  solution_t         skid;

  assign ce           = !skid_valid;
  assign target_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= LEN_RESET;
      lower_len <= LEN_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_UPPER) begin
        upper_len <= cfg_data;
      end
      if (cfg_index == REG_LOWER) begin
        lower_len <= cfg_data;
      end
    end
  end

  // products, radicand and denominators
  tlik_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (target_valid && !target_stall),
    .target    (target),
    .len_a     (upper_len),
    .len_b     (lower_len),
    .out_valid (fr_valid),
    .radicand  (fr_radicand),
    .side_out  (fr_side)
  );

  // floor square root of the discriminant
  tlik_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (fr_valid),
    .radicand  (fr_radicand),
    .side_in   (fr_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  // half-angle solve for both links
  tlik_vec #(.Stages(CORDIC_STAGES)) u_vec (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (sq_valid),
    .sd        (sq_root),
    .side_in   (sq_side),
    .out_valid (vc_valid),
    .ang_out   (vc_angles)
  );

  // cos/sin and forward kinematics
  tlik_rot #(.Stages(CORDIC_STAGES)) u_rot (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (vc_valid),
    .ang_in    (vc_angles),
    .out_valid (rt_valid),
    .sol_out   (rt_sol)
  );

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      solution_valid <= 1'b0;
      skid_valid     <= 1'b0;
    end else if (skid_valid) begin
      if (!solution_stall) begin
        solution_valid <= 1'b1;
        skid_valid     <= 1'b0;
      end
    end else if (!solution_valid || !solution_stall) begin
      solution_valid <= rt_valid;
    end else if (rt_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!solution_stall) begin
        solution <= skid;
      end
    end else if (!solution_valid || !solution_stall) begin
      solution <= rt_sol;
    end else if (rt_valid) begin
      skid <= rt_sol;
    end
  end

`ifndef SYNTHESIS
  // a skid word only exists behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> solution_valid)
    else $error("skid word without output word");

  // skid fills only when the output word was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(solution_valid && solution_stall))
    else $error("skid filled without a stall");

  // a failed solve carries all-zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (solution_valid && solution.status != ST_SOLVED) |->
      (solution.shoulder_angle == '0 && solution.second_link_angle == '0 &&
       solution.elbow_x == '0 && solution.elbow_y == '0 &&
       solution.tip_x == '0 && solution.tip_y == '0))
    else $error("failed solve with nonzero fields");
`endif

endmodule
`default_nettype wire

@@ sv/tlik_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_front
// Products and sums of the half-angle formulas, ending in the radicand.
// ----------------------------------------------------------------------------
module tlik_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ce,
  input  logic                   in_valid,
  input  tlik_pkg::target_t      target,
  input  logic [tlik_pkg::LenW-1:0] len_a,
  input  logic [tlik_pkg::LenW-1:0] len_b,
  output logic                   out_valid,
  output logic [63:0]            radicand,
  output tlik_pkg::front_t       side_out
);
  import tlik_pkg::*;

  logic v1, v2, v3, v4;

  // stage 1: sampled operands
  logic signed [NW-1:0] x1, y1, a1, b1;
  logic [LenW-1:0] la1, lb1;
  // stage 2: products
  logic signed [NW-1:0] xx2, yy2, ss2, dd2, ax2, bx2, ay2, by2, aa2, bb2;
  logic [LenW-1:0] la2, lb2;
  // stage 3: first sums
  logic signed [NW-1:0] r2_3, ss3, dd3, e0_3, e1_3, ay3, by3;
  logic [LenW-1:0] la3, lb3;
  // stage 4: factors and denominators
  logic signed [NW-1:0] p4, q4, den0_4, den1_4, ay4, by4;
  logic [LenW-1:0] la4, lb4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x1  <= NW'(target.target_x);
      y1  <= NW'(target.target_y);
      a1  <= $signed(NW'(len_a));
      b1  <= $signed(NW'(len_b));
      la1 <= len_a;
      lb1 <= len_b;

      xx2 <= x1 * x1;
      yy2 <= y1 * y1;
      ss2 <= (a1 + b1) * (a1 + b1);
      dd2 <= (a1 - b1) * (a1 - b1);
      ax2 <= a1 * x1;
      bx2 <= b1 * x1;
      ay2 <= a1 * y1;
      by2 <= b1 * y1;
      aa2 <= a1 * a1;
      bb2 <= b1 * b1;
      la2 <= la1;
      lb2 <= lb1;

      r2_3 <= xx2 + yy2;
      ss3  <= ss2;
      dd3  <= dd2;
      e0_3 <= aa2 - bb2 + (ax2 <<< 1);
      e1_3 <= bb2 - aa2 + (bx2 <<< 1);
      ay3  <= ay2 <<< 1;
      by3  <= by2 <<< 1;
      la3  <= la2;
      lb3  <= lb2;

      p4     <= ss3 - r2_3;
      q4     <= r2_3 - dd3;
      den0_4 <= e0_3 + r2_3;
      den1_4 <= e1_3 + r2_3;
      ay4    <= ay3;
      by4    <= by3;
      la4    <= la3;
      lb4    <= lb3;

      // both factors stay below 2^33 when in reach, product below 2^62
      radicand      <= p4[32:0] * q4[31:0];
      side_out.oor  <= p4[NW-1] | q4[NW-1];
      side_out.len_a <= la4;
      side_out.len_b <= lb4;
      side_out.ay2  <= ay4;
      side_out.by2  <= by4;
      side_out.den0 <= den0_4;
      side_out.den1 <= den1_4;
    end
  end

endmodule
`default_nettype wire

@@ sv/tlik_isqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_isqrt
// Pipelined floor square root of a 64-bit radicand, one result bit per stage.
// ----------------------------------------------------------------------------
module tlik_isqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             ce,
  input  logic             in_valid,
  input  logic [63:0]      radicand,
  input  tlik_pkg::front_t side_in,
  output logic             out_valid,
  output logic [31:0]      root,
  output tlik_pkg::front_t side_out
);
  import tlik_pkg::*;

  logic [63:0] rem  [0:SqrtSteps];
  logic [63:0] acc  [0:SqrtSteps];
  logic        vld  [0:SqrtSteps];
  front_t      side [0:SqrtSteps];

  assign rem[0]  = radicand;
  assign acc[0]  = '0;
  assign vld[0]  = in_valid;
  assign side[0] = side_in;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = acc[k] + Bit;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ce) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        side[k+1] <= side[k];
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          acc[k+1] <= (acc[k] >> 1) + Bit;
        end else begin
          rem[k+1] <= rem[k];
          acc[k+1] <= acc[k] >> 1;
        end
      end
    end
  end

  assign out_valid = vld[SqrtSteps];
  assign root      = acc[SqrtSteps][31:0];
  assign side_out  = side[SqrtSteps];

`ifndef SYNTHESIS
  // floor root leaves a remainder of at most twice the root
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    vld[SqrtSteps] |-> rem[SqrtSteps] <= (acc[SqrtSteps] << 1))
    else $error("square root remainder too large");
`endif

endmodule
`default_nettype wire

@@ sv/tlik_vec.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_vec
// Two-lane cordic vectoring: 2*atan(num/den) for shoulder and second link.
// ----------------------------------------------------------------------------
module tlik_vec #(
  parameter int Stages = tlik_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  logic [31:0]       sd,
  input  tlik_pkg::front_t  side_in,
  output logic              out_valid,
  output tlik_pkg::angles_t ang_out
);
  import tlik_pkg::*;

  logic signed [NW-1:0] sd_ext;
  assign sd_ext = $signed({{(NW - 32){1'b0}}, sd});

  // numerators
  logic                 v0;
  logic signed [NW-1:0] num_q [0:1];
  logic signed [NW-1:0] den_q [0:1];
  vec_side_t            s0;

  // sign fold and magnitude
  logic                 v1;
  logic signed [NW-1:0] xa [0:1];
  logic signed [NW-1:0] ya [0:1];
  logic signed [NW-1:0] yab [0:1];
  logic signed [NW-1:0] x1 [0:1];
  logic signed [NW-1:0] y1 [0:1];
  logic [NW-1:0]        m1 [0:1];
  vec_side_t            s1;

  // shift count
  logic                 v2;
  logic signed [NW-1:0] x2 [0:1];
  logic signed [NW-1:0] y2 [0:1];
  logic [KW-1:0]        k2 [0:1];
  vec_side_t            s2;

  // cordic lanes
  logic signed [CW-1:0] cx [0:Stages][0:1];
  logic signed [CW-1:0] cy [0:Stages][0:1];
  logic signed [ZW-1:0] cz [0:Stages][0:1];
  logic                 cv [0:Stages];
  vec_side_t            cs [0:Stages];

  logic signed [ZW-1:0] zz [0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      cv[0]     <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v0        <= in_valid;
      v1        <= v0;
      v2        <= v1;
      cv[0]     <= v2;
      out_valid <= cv[Stages];
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      xa[l]  = den_q[l][NW-1] ? -den_q[l] : den_q[l];
      ya[l]  = den_q[l][NW-1] ? -num_q[l] : num_q[l];
      yab[l] = ya[l][NW-1] ? -ya[l] : ya[l];
      zz[l]  = (cz[Stages][l] <<< 1) + ZW'(32768);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      num_q[0] <= side_in.ay2 - sd_ext;
      num_q[1] <= side_in.by2 + sd_ext;
      den_q[0] <= side_in.den0;
      den_q[1] <= side_in.den1;
      s0.oor   <= side_in.oor;
      s0.sing  <= 1'b0;
      s0.pi0   <= 1'b0;
      s0.pi1   <= 1'b0;
      s0.len_a <= side_in.len_a;
      s0.len_b <= side_in.len_b;

      for (int l = 0; l < 2; l++) begin
        x1[l] <= xa[l];
        y1[l] <= ya[l];
        m1[l] <= (xa[l] > yab[l]) ? xa[l] : yab[l];
      end
      s1.oor   <= s0.oor;
      s1.len_a <= s0.len_a;
      s1.len_b <= s0.len_b;
      s1.pi0   <= den_q[0] == '0;
      s1.pi1   <= den_q[1] == '0;
      s1.sing  <= (den_q[0] == '0 && num_q[0] == '0) ||
                  (den_q[1] == '0 && num_q[1] == '0);

      for (int l = 0; l < 2; l++) begin
        x2[l] <= x1[l];
        y2[l] <= y1[l];
        k2[l] <= norm_shift(m1[l]);
      end
      s2 <= s1;

      for (int l = 0; l < 2; l++) begin
        cx[0][l] <= CW'(x2[l]) <<< k2[l];
        cy[0][l] <= CW'(y2[l]) <<< k2[l];
        cz[0][l] <= '0;
      end
      cs[0] <= s2;

      ang_out.ang0  <= cs[Stages].pi0 ? ANG_PI : zz[0][31:16];
      ang_out.ang1  <= cs[Stages].pi1 ? ANG_PI : zz[1][31:16];
      ang_out.len_a <= cs[Stages].len_a;
      ang_out.len_b <= cs[Stages].len_b;
      if (cs[Stages].oor) begin
        ang_out.status <= ST_OUT_OF_REACH;
      end else if (cs[Stages].sing) begin
        ang_out.status <= ST_SINGULAR;
      end else begin
        ang_out.status <= ST_SOLVED;
      end
    end
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[s+1] <= 1'b0;
      end else if (ce) begin
        cv[s+1] <= cv[s];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        cs[s+1] <= cs[s];
        for (int l = 0; l < 2; l++) begin
          if (cy[s][l][CW-1]) begin
            cx[s+1][l] <= cx[s][l] - (cy[s][l] >>> s);
            cy[s+1][l] <= cy[s][l] + (cx[s][l] >>> s);
            cz[s+1][l] <= cz[s][l] - atan_tab(s);
          end else begin
            cx[s+1][l] <= cx[s][l] + (cy[s][l] >>> s);
            cy[s+1][l] <= cy[s][l] - (cx[s][l] >>> s);
            cz[s+1][l] <= cz[s][l] + atan_tab(s);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/tlik_rot.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_rot
// Two-lane cordic rotation for cos/sin, then elbow and tip positions.
// ----------------------------------------------------------------------------
module tlik_rot #(
  parameter int Stages = tlik_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  logic                in_valid,
  input  tlik_pkg::angles_t   ang_in,
  output logic                out_valid,
  output tlik_pkg::solution_t sol_out
);
  import tlik_pkg::*;

  typedef struct packed {
    logic [AngW-1:0] ang0;
    logic [AngW-1:0] ang1;
    status_t         status;
    logic [LenW-1:0] len_a;
    logic [LenW-1:0] len_b;
    logic            flip0;
    logic            flip1;
  } rot_side_t;

  localparam logic signed [ZW-1:0] HalfPi = ZW'(64'sd1 << 30);
  localparam logic signed [ZW-1:0] Pi     = ZW'(64'sd1 << 31);

  logic signed [ZW-1:0] z_in [0:1];
  logic                 fl_in [0:1];

  logic signed [RW-1:0] rx [0:Stages][0:1];
  logic signed [RW-1:0] ry [0:Stages][0:1];
  logic signed [ZW-1:0] rz [0:Stages][0:1];
  logic                 rv [0:Stages];
  rot_side_t            rs [0:Stages];

  // forward kinematics stages
  logic                 f1v, f2v;
  logic signed [RW-1:0] c_f [0:1];
  logic signed [RW-1:0] s_f [0:1];
  logic signed [PW-1:0] pc0, ps0, pc1, ps1;
  rot_side_t            fs1, fs2;
  logic signed [PW-1:0] rc0, rs0, rc1, rs1;
  logic signed [CoordW-1:0] ex2, ey2;
  logic signed [SatW-1:0]   bx2, by2;
  logic signed [SatW-1:0]   tx_sum, ty_sum;
  logic signed [CoordW-1:0] tx, ty;
  logic                     solved;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      z_in[l]  = ZW'($signed(l == 0 ? ang_in.ang0 : ang_in.ang1)) <<< 16;
      fl_in[l] = (z_in[l] > HalfPi) || (z_in[l] < -HalfPi);
      if (z_in[l] > HalfPi) begin
        z_in[l] = z_in[l] - Pi;
      end else if (z_in[l] < -HalfPi) begin
        z_in[l] = z_in[l] + Pi;
      end
      c_f[l] = rs[Stages].flip0 ? -rx[Stages][l] : rx[Stages][l];
      s_f[l] = rs[Stages].flip0 ? -ry[Stages][l] : ry[Stages][l];
      if (l == 1) begin
        c_f[l] = rs[Stages].flip1 ? -rx[Stages][l] : rx[Stages][l];
        s_f[l] = rs[Stages].flip1 ? -ry[Stages][l] : ry[Stages][l];
      end
    end
    rc0    = pc0 + PW'(64'sd1 << 29);
    rs0    = ps0 + PW'(64'sd1 << 29);
    rc1    = pc1 + PW'(64'sd1 << 29);
    rs1    = ps1 + PW'(64'sd1 << 29);
    tx_sum = SatW'(ex2) + bx2;
    ty_sum = SatW'(ey2) + by2;
    tx     = sat_coord(tx_sum);
    ty     = sat_coord(ty_sum);
    solved = fs2.status == ST_SOLVED;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0]     <= 1'b0;
      f1v       <= 1'b0;
      f2v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      rv[0]     <= in_valid;
      f1v       <= rv[Stages];
      f2v       <= f1v;
      out_valid <= f2v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int l = 0; l < 2; l++) begin
        rx[0][l] <= GAIN_Q30;
        ry[0][l] <= '0;
        rz[0][l] <= z_in[l];
      end
      rs[0].ang0   <= ang_in.ang0;
      rs[0].ang1   <= ang_in.ang1;
      rs[0].status <= ang_in.status;
      rs[0].len_a  <= ang_in.len_a;
      rs[0].len_b  <= ang_in.len_b;
      rs[0].flip0  <= fl_in[0];
      rs[0].flip1  <= fl_in[1];

      pc0 <= $signed({1'b0, rs[Stages].len_a}) * c_f[0];
      ps0 <= $signed({1'b0, rs[Stages].len_a}) * s_f[0];
      pc1 <= $signed({1'b0, rs[Stages].len_b}) * c_f[1];
      ps1 <= $signed({1'b0, rs[Stages].len_b}) * s_f[1];
      fs1 <= rs[Stages];

      // round half up, drop q30
      ex2 <= sat_coord(SatW'($signed(rc0[PW-1:30])));
      ey2 <= sat_coord(SatW'($signed(rs0[PW-1:30])));
      bx2 <= SatW'($signed(rc1[PW-1:30]));
      by2 <= SatW'($signed(rs1[PW-1:30]));
      fs2 <= fs1;

      sol_out.shoulder_angle    <= solved ? $signed(fs2.ang0) : '0;
      sol_out.second_link_angle <= solved ? $signed(fs2.ang1) : '0;
      sol_out.elbow_x           <= solved ? ex2 : '0;
      sol_out.elbow_y           <= solved ? ey2 : '0;
      sol_out.tip_x             <= solved ? tx : '0;
      sol_out.tip_y             <= solved ? ty : '0;
      sol_out.status            <= fs2.status;
    end
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        rv[s+1] <= 1'b0;
      end else if (ce) begin
        rv[s+1] <= rv[s];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rs[s+1] <= rs[s];
        for (int l = 0; l < 2; l++) begin
          if (!rz[s][l][ZW-1]) begin
            rx[s+1][l] <= rx[s][l] - (ry[s][l] >>> s);
            ry[s+1][l] <= ry[s][l] + (rx[s][l] >>> s);
            rz[s+1][l] <= rz[s][l] - atan_tab(s);
          end else begin
            rx[s+1][l] <= rx[s][l] + (ry[s][l] >>> s);
            ry[s+1][l] <= ry[s][l] - (rx[s][l] >>> s);
            rz[s+1][l] <= rz[s][l] + atan_tab(s);
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  // after the half-turn fold the rotation angle stays within a quarter turn
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    rv[0] |-> (rz[0][0] <= HalfPi && rz[0][0] >= -HalfPi &&
               rz[0][1] <= HalfPi && rz[0][1] >= -HalfPi))
    else $error("rotation angle outside quarter turn");
`endif

endmodule
`default_nettype wire
